[hdl/tcpc_pkg.sv]
`default_nettype none
// shared types and constants of the tolerant color palette collector
package tcpc_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CHAN_W = 8;
	localparam int TOL_W = 9;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              restart;
	} pixel_t;

	typedef struct packed {
		logic [2:0] slot;
		logic       is_new;
		logic       overflow;
		logic [3:0] fill_count;
	} result_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} color_t;

	typedef struct packed {
		logic             valid;
		logic             clear;
		logic             write;
		logic [IDX_W-1:0] index;
		color_t           color;
		logic [CNT_W-1:0] count;
	} update_t;

endpackage
`default_nettype wire

[hdl/tcpc_store.sv]
`default_nettype none
// palette storage: used marks, stored colors and entry count
module tcpc_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tcpc_pkg::update_t             upd,
	output logic [tcpc_pkg::ENTRIES-1:0]       used,
	output tcpc_pkg::color_t                   colors [tcpc_pkg::ENTRIES],
	output logic [tcpc_pkg::CNT_W-1:0]         count
);

	logic [tcpc_pkg::ENTRIES-1:0] used_q;
	tcpc_pkg::color_t             color_q [tcpc_pkg::ENTRIES];
	logic [tcpc_pkg::CNT_W-1:0]   count_q;
	logic [tcpc_pkg::ENTRIES-1:0] used_next;

	always_comb begin
		used_next = upd.clear ? '0 : used_q;
		if (upd.write) begin
			used_next[upd.index] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (upd.valid) begin
			used_q  <= used_next;
			count_q <= upd.count;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.valid && upd.write) begin
			color_q[upd.index] <= upd.color;
		end
	end

	assign used   = used_q;
	assign colors = color_q;
	assign count  = count_q;

endmodule
`default_nettype wire

[hdl/tcpc_match.sv]
`default_nettype none
// parallel tolerance compare, first-match and first-free pick, result build
module tcpc_match (
	input  wire tcpc_pkg::pixel_t              pix,
	input  wire logic                          pix_valid,
	input  wire logic [tcpc_pkg::ENTRIES-1:0]  used,
	input  wire tcpc_pkg::color_t              colors [tcpc_pkg::ENTRIES],
	input  wire logic [tcpc_pkg::CNT_W-1:0]    count,
	input  wire logic [tcpc_pkg::TOL_W-1:0]    tol,
	output tcpc_pkg::update_t                  upd,
	output tcpc_pkg::result_t                  res
);

	logic [tcpc_pkg::ENTRIES-1:0] used_eff;
	logic [tcpc_pkg::ENTRIES-1:0] hit;
	logic [tcpc_pkg::CNT_W-1:0]   count_eff;
	logic [tcpc_pkg::CNT_W-1:0]   count_next;
	logic [tcpc_pkg::IDX_W-1:0]   hit_idx;
	logic [tcpc_pkg::IDX_W-1:0]   free_idx;
	logic [tcpc_pkg::IDX_W-1:0]   slot_idx;
	logic                         found;
	logic                         has_free;
	logic                         store_new;

	function automatic logic chan_close(input logic [tcpc_pkg::CHAN_W-1:0] a,
		input logic [tcpc_pkg::CHAN_W-1:0] b, input logic [tcpc_pkg::TOL_W-1:0] t);
		logic [tcpc_pkg::CHAN_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return tcpc_pkg::TOL_W'(d) < t;
	endfunction

	assign used_eff  = pix.restart ? '0 : used;
	assign count_eff = pix.restart ? '0 : count;

	always_comb begin
		for (int i = 0; i < tcpc_pkg::ENTRIES; i++) begin
			hit[i] = used_eff[i]
				&& chan_close(pix.red,   colors[i].red,   tol)
				&& chan_close(pix.green, colors[i].green, tol)
				&& chan_close(pix.blue,  colors[i].blue,  tol);
		end
	end

	// lowest index wins
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = tcpc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = tcpc_pkg::IDX_W'(i);
			end
			if (!used_eff[i]) begin
				free_idx = tcpc_pkg::IDX_W'(i);
			end
		end
	end

	assign found     = |hit;
	assign has_free  = ~&used_eff;
	assign store_new = !found && has_free;
	assign count_next = store_new ? count_eff + tcpc_pkg::CNT_W'(1) : count_eff;

	always_comb begin
		if (found) begin
			slot_idx = hit_idx;
		end else if (has_free) begin
			slot_idx = free_idx;
		end else begin
			slot_idx = '0;
		end
	end

	always_comb begin
		upd.valid     = pix_valid;
		upd.clear     = pix.restart;
		upd.write     = store_new;
		upd.index     = free_idx;
		upd.color.red   = pix.red;
		upd.color.green = pix.green;
		upd.color.blue  = pix.blue;
		upd.count     = count_next;

		res.slot        = 3'(slot_idx);
		res.is_new      = store_new;
		res.overflow    = !found && !has_free;
		res.fill_count  = 4'(count_next);
	end

endmodule
`default_nettype wire

[hdl/tolerant_color_palette_collector_core.sv]
`default_nettype none
// top level of the tolerant color palette collector
//
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// pixel in  | start, busy (always low)  | pixel: red, green, blue, restart
// result    | done strobe, one cycle    | result: slot, is_new, overflow, fill_count
// config    | cfg_valid, cfg_ready      | cfg_data: match_tolerance
//
// one pixel per cycle; a result passes from its start through the input
// register, then the result register, set by the single compare pass
// against all palette entries and the palette update at the same edge
// reset clears the palette, the count and sets match_tolerance to 16
// the receiver cannot stall; results are strobed once and not held
module tolerant_color_palette_collector_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire tcpc_pkg::pixel_t             pixel,
	output logic                              done,
	output tcpc_pkg::result_t                 result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tcpc_pkg::TOL_W-1:0]   cfg_data
);

	tcpc_pkg::pixel_t             pix_s1;
	logic                         valid_s1;
	tcpc_pkg::result_t            res_s2;
	logic                         valid_s2;
	logic [tcpc_pkg::TOL_W-1:0]   tol_q;

	tcpc_pkg::update_t            upd;
	tcpc_pkg::result_t            res;
	logic [tcpc_pkg::ENTRIES-1:0] used;
	tcpc_pkg::color_t             colors [tcpc_pkg::ENTRIES];
	logic [tcpc_pkg::CNT_W-1:0]   count;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= tcpc_pkg::TOL_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1 <= pixel;
		end
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	tcpc_match u_match (
		.pix       (pix_s1),
		.pix_valid (valid_s1),
		.used      (used),
		.colors    (colors),
		.count     (count),
		.tol       (tol_q),
		.upd       (upd),
		.res       (res)
	);

	tcpc_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.used   (used),
		.colors (colors),
		.count  (count)
	);

	assign done   = valid_s2;
	assign result = res_s2;

endmodule
`default_nettype wire
